// ===== rtl/fcrl_pkg.sv =====
package fcrl_pkg;

   // table geometry
   localparam int SLOTS  = 64;
   localparam int SLOT_W = 6;
   localparam int LINK_W = 7;
   localparam int CNT_W  = 7;
   localparam int TAG_W  = 32;
   localparam int CAP_W  = 7;
   localparam int CSR_DW = 32;
   localparam int CSR_AW = 3;

   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOTS);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
   localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;

   // register index
   localparam logic CSR_CAPACITY = 1'b0;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_ERASE  = 1'b1;

   // outcome codes
   localparam logic [1:0] OUT_STORED  = 2'd0;
   localparam logic [1:0] OUT_EVICTED = 2'd1;
   localparam logic [1:0] OUT_ERASED  = 2'd2;
   localparam logic [1:0] OUT_MISSING = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_SCAN,
      ST_ERA_RD,
      ST_ERA_WR,
      ST_DONE
   } state_type;

   // access command from the sequencer to the table
   typedef struct packed {
      logic [SLOT_W-1:0] tag_rd_addr;
      logic              tag_wr_en;
      logic [SLOT_W-1:0] tag_wr_addr;
      logic [TAG_W-1:0]  tag_wr_data;
      logic              vld_set;
      logic              vld_clr;
      logic [SLOT_W-1:0] vld_addr;
      logic [SLOT_W-1:0] lnk_rd_addr;
      logic              newer_wr_en;
      logic [SLOT_W-1:0] newer_wr_addr;
      logic [LINK_W-1:0] newer_wr_data;
      logic              older_wr_en;
      logic [SLOT_W-1:0] older_wr_addr;
      logic [LINK_W-1:0] older_wr_data;
      logic [SLOT_W-1:0] free_rd_addr;
      logic              free_wr_en;
      logic [SLOT_W-1:0] free_wr_addr;
      logic [SLOT_W-1:0] free_wr_data;
   } tbl_cmd_type;

   // registered read data from the table
   typedef struct packed {
      logic [TAG_W-1:0]  tag_q;
      logic              vld_q;
      logic [LINK_W-1:0] newer_q;
      logic [LINK_W-1:0] older_q;
      logic [SLOT_W-1:0] free_q;
   } tbl_rd_type;

endpackage

// ===== rtl/fcrl_req_if.sv =====
interface fcrl_req_if;
   import fcrl_pkg::*;

   logic              valid;
   logic              ready;
   logic              op;
   logic [TAG_W-1:0]  key_tag;

   modport source (output valid, output op, output key_tag, input ready);
   modport sink   (input valid, input op, input key_tag, output ready);
endinterface

// ===== rtl/fcrl_rsp_if.sv =====
interface fcrl_rsp_if;
   import fcrl_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        outcome;
   logic [SLOT_W-1:0] slot;
   logic [TAG_W-1:0]  evicted_tag;
   logic [CNT_W-1:0]  entries_held;

   modport source (output valid, output outcome, output slot, output evicted_tag,
                   output entries_held, input ready);
   modport sink   (input valid, input outcome, input slot, input evicted_tag,
                   input entries_held, output ready);
endinterface

// ===== rtl/fcrl_csr.sv =====
module fcrl_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fcrl_pkg::CSR_AW-1:0]    paddr,
   input  logic [fcrl_pkg::CSR_DW-1:0]    pwdata,
   output logic [fcrl_pkg::CSR_DW-1:0]    prdata,
   output logic                           pready,
   output logic [fcrl_pkg::CAP_W-1:0]     capacity
);
   import fcrl_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_in;
   logic             reg_sel;

   assign reg_sel = (paddr[2] == CSR_CAPACITY);
   assign pready  = 1'b1;

   // capacity register write
   always_comb begin
      cap_in = cap_ff;
      if (psel && penable && pwrite && reg_sel) begin
         cap_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // read back
   assign prdata   = reg_sel ? CSR_DW'(cap_ff) : '0;
   assign capacity = cap_ff;

endmodule

// ===== rtl/fcrl_table.sv =====
module fcrl_table (
   input  logic                  clock,
   input  logic                  reset,
   input  fcrl_pkg::tbl_cmd_type cmd,
   output fcrl_pkg::tbl_rd_type  rd
);
   import fcrl_pkg::*;

   logic [TAG_W-1:0]  tag_mem   [SLOTS];
   logic [LINK_W-1:0] newer_mem [SLOTS];
   logic [LINK_W-1:0] older_mem [SLOTS];
   logic [SLOT_W-1:0] free_mem  [SLOTS];

   logic [SLOTS-1:0]  vld_ff;
   logic [SLOTS-1:0]  vld_in;
   logic [SLOTS-1:0]  fwr_ff;
   logic [SLOTS-1:0]  fwr_in;

   logic [TAG_W-1:0]  tag_q_ff;
   logic              vld_q_ff;
   logic [LINK_W-1:0] newer_q_ff;
   logic [LINK_W-1:0] older_q_ff;
   logic [SLOT_W-1:0] free_dat_ff;
   logic              free_wr_q_ff;
   logic [SLOT_W-1:0] free_addr_q_ff;

   // tag memory
   always_ff @(posedge clock) begin
      if (cmd.tag_wr_en) begin
         tag_mem[cmd.tag_wr_addr] <= cmd.tag_wr_data;
      end
      tag_q_ff <= tag_mem[cmd.tag_rd_addr];
      vld_q_ff <= vld_ff[cmd.tag_rd_addr];
   end

   // link memories
   always_ff @(posedge clock) begin
      if (cmd.newer_wr_en) begin
         newer_mem[cmd.newer_wr_addr] <= cmd.newer_wr_data;
      end
      if (cmd.older_wr_en) begin
         older_mem[cmd.older_wr_addr] <= cmd.older_wr_data;
      end
      newer_q_ff <= newer_mem[cmd.lnk_rd_addr];
      older_q_ff <= older_mem[cmd.lnk_rd_addr];
   end

   // free-slot stack; an entry never written reads back as its own index
   always_ff @(posedge clock) begin
      if (cmd.free_wr_en) begin
         free_mem[cmd.free_wr_addr] <= cmd.free_wr_data;
      end
      free_dat_ff    <= free_mem[cmd.free_rd_addr];
      free_addr_q_ff <= cmd.free_rd_addr;
   end

   // valid and stack-written flags
   always_comb begin
      vld_in = vld_ff;
      fwr_in = fwr_ff;
      if (cmd.vld_set) vld_in[cmd.vld_addr] = 1'b1;
      if (cmd.vld_clr) vld_in[cmd.vld_addr] = 1'b0;
      if (cmd.free_wr_en) fwr_in[cmd.free_wr_addr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         fwr_ff       <= '0;
         free_wr_q_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         fwr_ff       <= fwr_in;
         free_wr_q_ff <= fwr_ff[cmd.free_rd_addr];
      end
   end

   assign rd.tag_q   = tag_q_ff;
   assign rd.vld_q   = vld_q_ff;
   assign rd.newer_q = newer_q_ff;
   assign rd.older_q = older_q_ff;
   assign rd.free_q  = free_wr_q_ff ? free_dat_ff : free_addr_q_ff;

endmodule

// ===== rtl/fcrl_ctrl.sv =====
module fcrl_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [fcrl_pkg::CAP_W-1:0]  capacity,
   fcrl_req_if.sink                    req_ch,
   fcrl_rsp_if.source                  rsp_ch,
   output fcrl_pkg::tbl_cmd_type       cmd,
   input  fcrl_pkg::tbl_rd_type        rd
);
   import fcrl_pkg::*;

   state_type         state_ff, state_in;
   logic              op_ff, op_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              evict_ff, evict_in;
   logic [LINK_W-1:0] newest_ff, newest_in;
   logic [LINK_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [SLOT_W-1:0] scan_idx_ff, scan_idx_in;
   logic              scan_end_ff, scan_end_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [SLOT_W-1:0] found_ff, found_in;
   logic [1:0]        res_out_ff, res_out_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [TAG_W-1:0]  res_evt_ff, res_evt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_out_ff, rsp_out_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [TAG_W-1:0]  rsp_evt_ff, rsp_evt_in;
   logic [CNT_W-1:0]  rsp_held_ff, rsp_held_in;

   logic [CAP_W-1:0]  cap_eff;
   logic              accept;
   logic              hit;
   logic              rsp_free;
   logic [LINK_W-1:0] nw;
   logic [LINK_W-1:0] ol;
   logic [LINK_W-1:0] newest1;
   logic [CNT_W-1:0]  held1;
   logic [SLOT_W-1:0] ins_slot;

   // clamp capacity into 1..SLOTS
   always_comb begin
      if (capacity == '0) cap_eff = CAP_W'(1);
      else if (capacity > CAP_W'(SLOTS)) cap_eff = CAP_W'(SLOTS);
      else cap_eff = capacity;
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign hit          = cmp_vld_ff && rd.vld_q && (rd.tag_q == tag_ff);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = (req_ch.op == OP_ERASE) ? ST_SCAN : ST_INS_RD;
         end
         ST_INS_RD: state_in = ST_INS_WR;
         ST_INS_WR: state_in = ST_DONE;
         ST_SCAN: begin
            if (hit) state_in = ST_ERA_RD;
            else if (cmp_vld_ff && cmp_idx_ff == SLOT_LAST) state_in = ST_DONE;
         end
         ST_ERA_RD: state_in = ST_ERA_WR;
         ST_ERA_WR: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and table commands
   always_comb begin
      op_in       = op_ff;
      tag_in      = tag_ff;
      evict_in    = evict_ff;
      newest_in   = newest_ff;
      oldest_in   = oldest_ff;
      held_in     = held_ff;
      scan_idx_in = scan_idx_ff;
      scan_end_in = scan_end_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      found_in    = found_ff;
      res_out_in  = res_out_ff;
      res_slot_in = res_slot_ff;
      res_evt_in  = res_evt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_out_in  = rsp_out_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_evt_in  = rsp_evt_ff;
      rsp_held_in = rsp_held_ff;
      nw          = LINK_NONE;
      ol          = LINK_NONE;
      newest1     = newest_ff;
      held1       = held_ff;
      ins_slot    = rd.free_q;

      cmd               = '0;
      cmd.tag_rd_addr   = oldest_ff[SLOT_W-1:0];
      cmd.lnk_rd_addr   = oldest_ff[SLOT_W-1:0];
      cmd.free_rd_addr  = held_ff[SLOT_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_ch.op;
               tag_in      = req_ch.key_tag;
               evict_in    = (held_ff >= cap_eff) && (oldest_ff != LINK_NONE);
               scan_idx_in = '0;
               scan_end_in = 1'b0;
            end
         end
         ST_INS_RD: begin
            // addresses above: oldest slot and stack top
         end
         ST_INS_WR: begin
            // drop the oldest entry first if at capacity
            if (evict_ff) begin
               nw       = (oldest_ff == newest_ff) ? LINK_NONE : rd.newer_q;
               newest1  = (oldest_ff == newest_ff) ? LINK_NONE : newest_ff;
               held1    = held_ff - CNT_W'(1);
               ins_slot = oldest_ff[SLOT_W-1:0];
            end
            cmd.tag_wr_en     = 1'b1;
            cmd.tag_wr_addr   = ins_slot;
            cmd.tag_wr_data   = tag_ff;
            cmd.vld_set       = 1'b1;
            cmd.vld_addr      = ins_slot;
            cmd.older_wr_en   = 1'b1;
            cmd.older_wr_addr = ins_slot;
            cmd.older_wr_data = newest1;
            cmd.newer_wr_en   = (newest1 != LINK_NONE);
            cmd.newer_wr_addr = newest1[SLOT_W-1:0];
            cmd.newer_wr_data = {1'b0, ins_slot};
            if (newest1 == LINK_NONE) oldest_in = {1'b0, ins_slot};
            else if (evict_ff) oldest_in = nw;
            newest_in   = {1'b0, ins_slot};
            held_in     = held1 + CNT_W'(1);
            res_out_in  = evict_ff ? OUT_EVICTED : OUT_STORED;
            res_slot_in = ins_slot;
            res_evt_in  = evict_ff ? rd.tag_q : '0;
         end
         ST_SCAN: begin
            // one tag read per cycle, compare in the cycle after
            cmd.tag_rd_addr = scan_idx_ff;
            cmp_vld_in      = !scan_end_ff;
            cmp_idx_in      = scan_idx_ff;
            scan_idx_in     = scan_idx_ff + SLOT_W'(1);
            scan_end_in     = scan_end_ff || (scan_idx_ff == SLOT_LAST);
            if (hit) begin
               found_in = cmp_idx_ff;
            end else if (cmp_vld_ff && cmp_idx_ff == SLOT_LAST) begin
               res_out_in  = OUT_MISSING;
               res_slot_in = '0;
               res_evt_in  = '0;
            end
         end
         ST_ERA_RD: begin
            cmd.lnk_rd_addr = found_ff;
         end
         ST_ERA_WR: begin
            // unlink the found slot and push it on the free stack
            nw = ({1'b0, found_ff} == newest_ff) ? LINK_NONE : rd.newer_q;
            ol = ({1'b0, found_ff} == oldest_ff) ? LINK_NONE : rd.older_q;
            if ({1'b0, found_ff} == newest_ff) begin
               newest_in = ol;
            end else if (nw != LINK_NONE) begin
               cmd.older_wr_en   = 1'b1;
               cmd.older_wr_addr = nw[SLOT_W-1:0];
               cmd.older_wr_data = ol;
            end
            if ({1'b0, found_ff} == oldest_ff) begin
               oldest_in = nw;
            end else if (ol != LINK_NONE) begin
               cmd.newer_wr_en   = 1'b1;
               cmd.newer_wr_addr = ol[SLOT_W-1:0];
               cmd.newer_wr_data = nw;
            end
            held1            = held_ff - CNT_W'(1);
            cmd.vld_clr      = 1'b1;
            cmd.vld_addr     = found_ff;
            cmd.free_wr_en   = 1'b1;
            cmd.free_wr_addr = held1[SLOT_W-1:0];
            cmd.free_wr_data = found_ff;
            held_in          = held1;
            res_out_in       = OUT_ERASED;
            res_slot_in      = found_ff;
            res_evt_in       = '0;
         end
         ST_DONE: begin
            // hand the word to the output register
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_out_in   = res_out_ff;
               rsp_slot_in  = res_slot_ff;
               rsp_evt_in   = res_evt_ff;
               rsp_held_in  = held_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         newest_ff    <= LINK_NONE;
         oldest_ff    <= LINK_NONE;
         held_ff      <= '0;
         scan_end_ff  <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         newest_ff    <= newest_in;
         oldest_ff    <= oldest_in;
         held_ff      <= held_in;
         scan_end_ff  <= scan_end_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tag_ff      <= tag_in;
      evict_ff    <= evict_in;
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      found_ff    <= found_in;
      res_out_ff  <= res_out_in;
      res_slot_ff <= res_slot_in;
      res_evt_ff  <= res_evt_in;
      rsp_out_ff  <= rsp_out_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_evt_ff  <= rsp_evt_in;
      rsp_held_ff <= rsp_held_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.outcome      = rsp_out_ff;
   assign rsp_ch.slot         = rsp_slot_ff;
   assign rsp_ch.evicted_tag  = rsp_evt_ff;
   assign rsp_ch.entries_held = rsp_held_ff;

`ifndef SYNTH
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_FULL) else $error("entry count above slot total");
   a_list_empty: assert property (@(posedge clock) disable iff (reset)
      (held_ff == '0) == (newest_ff == LINK_NONE)) else $error("list and count disagree");
   a_ends_empty: assert property (@(posedge clock) disable iff (reset)
      (newest_ff == LINK_NONE) == (oldest_ff == LINK_NONE)) else $error("list ends disagree");
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> rsp_valid_ff) else $error("result word lost");
   a_op_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (op_ff == OP_ERASE)) else $error("scan on insert");
`endif

endmodule

// ===== rtl/fifo_cache_replacement_list_core.sv =====
// Insert: read and write-back states, then the result word moves to the output register.
// Erase: the tag scan reads one slot of the tag memory per cycle; a match ends the scan and
// goes through the erase read and write-back states, a miss ends after the last slot.
// One item at a time: ready returns as the result word enters the output register; a stalled
// result word holds the next result in the done state until it is taken.
// Reset (synchronous, active high) empties the list and clears the slot valid flags.
module fifo_cache_replacement_list_core (
   input  logic                         clock,
   input  logic                         reset,
   fcrl_req_if.sink                     req_ch,
   fcrl_rsp_if.source                   rsp_ch,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [fcrl_pkg::CSR_AW-1:0]  paddr,
   input  logic [fcrl_pkg::CSR_DW-1:0]  pwdata,
   output logic [fcrl_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready
);
   // Reset also sets the capacity to 64; no clearing pass is needed.
   import fcrl_pkg::*;

   logic [CAP_W-1:0] capacity;
   tbl_cmd_type      cmd;
   tbl_rd_type       rd;

   // configuration
   fcrl_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   // sequencer
   fcrl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .capacity (capacity),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .cmd      (cmd),
      .rd       (rd)
   );

   // slot table memories
   fcrl_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rd    (rd)
   );

endmodule

// ===== bench/fcrl_checker.sv =====
`timescale 1ns / 100ps

module fcrl_checker
   import fcrl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   fcrl_req_if               req_ch,
   fcrl_rsp_if               rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output int                fail_count,
   output int                pending_count,
   output int                words_checked
);

   typedef struct packed {
      logic [1:0]        outcome;
      logic [SLOT_W-1:0] slot;
      logic [TAG_W-1:0]  evicted_tag;
      logic [CNT_W-1:0]  entries_held;
   } fifo_result_type;

   // shadow copy of the slot table
   logic [TAG_W-1:0] tag_mem   [SLOTS];
   bit               slot_used [SLOTS];
   int               newer_of  [SLOTS];
   int               older_of  [SLOTS];
   int               free_slots[SLOTS];
   int               newest, oldest, held;
   logic [CAP_W-1:0] capacity;

   fifo_result_type expected_results[$];

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic void clear_table();
      for (int i = 0; i < SLOTS; i++) begin
         slot_used[i]  = 0;
         newer_of[i]   = SLOTS;
         older_of[i]   = SLOTS;
         free_slots[i] = i;
      end
      newest   = SLOTS;
      oldest   = SLOTS;
      held     = 0;
      capacity = CAP_RESET;
   endfunction

   function automatic void free_slot(int s);
      int nw, ol;
      nw = newer_of[s];
      ol = older_of[s];
      if (s == newest) newest = ol;
      else if (nw < SLOTS) older_of[nw] = ol;
      if (s == oldest) oldest = nw;
      else if (ol < SLOTS) newer_of[ol] = nw;
      slot_used[s] = 0;
      newer_of[s]  = SLOTS;
      older_of[s]  = SLOTS;
      if (held > 0) held--;
      free_slots[held] = s;
   endfunction

   function automatic fifo_result_type apply_request(logic op, logic [TAG_W-1:0] tag);
      fifo_result_type r;
      int limit, s, hit;
      r = '0;
      if (op == OP_INSERT) begin
         limit = (capacity < 1) ? 1 : (capacity > SLOTS) ? SLOTS : capacity;
         // evict oldest once when at capacity
         if (held >= limit && oldest < SLOTS) begin
            r.evicted_tag = tag_mem[oldest];
            free_slot(oldest);
            r.outcome = OUT_EVICTED;
         end else begin
            r.outcome = OUT_STORED;
         end
         if (held < SLOTS) begin
            s = free_slots[held];
            tag_mem[s]   = tag;
            slot_used[s] = 1;
            newer_of[s]  = SLOTS;
            older_of[s]  = newest;
            if (newest < SLOTS) newer_of[newest] = s;
            else oldest = s;
            newest = s;
            held++;
            r.slot = SLOT_W'(s);
         end
      end else begin
         // lowest matching valid slot wins
         hit = SLOTS;
         for (int i = 0; i < SLOTS; i++)
            if (hit == SLOTS && slot_used[i] && tag_mem[i] == tag) hit = i;
         if (hit < SLOTS) begin
            free_slot(hit);
            r.outcome = OUT_ERASED;
            r.slot    = SLOT_W'(hit);
         end else begin
            r.outcome = OUT_MISSING;
         end
      end
      r.entries_held = CNT_W'(held);
      return r;
   endfunction

   initial begin
      fail_count    = 0;
      words_checked = 0;
      clear_table();
   end

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      fifo_result_type want;
      if (reset) begin
         clear_table();
         expected_results.delete();
      end else begin
         // register writes
         if (psel && penable && pwrite && pready && paddr[2] == CSR_CAPACITY)
            capacity = pwdata[CAP_W-1:0];
         // result words against the oldest expectation
         if (rsp_ch.valid && rsp_ch.ready) begin
            words_checked++;
            if (expected_results.size() == 0) begin
               report("unexpected result word", 0, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.outcome !== want.outcome)
                  report("outcome", rsp_ch.outcome, want.outcome);
               if (rsp_ch.slot !== want.slot)
                  report("slot", rsp_ch.slot, want.slot);
               if (rsp_ch.evicted_tag !== want.evicted_tag)
                  report("evicted_tag", rsp_ch.evicted_tag, want.evicted_tag);
               if (rsp_ch.entries_held !== want.entries_held)
                  report("entries_held", rsp_ch.entries_held, want.entries_held);
            end
         end
         // accepted request words
         if (req_ch.valid && req_ch.ready)
            expected_results.push_back(apply_request(req_ch.op, req_ch.key_tag));
      end
   end

   final begin
      if (expected_results.size() != 0)
         $display("%0d result words never arrived", expected_results.size());
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import fcrl_pkg::*;

   logic              clock = 0;
   logic              reset = 1;
   logic              psel = 0, penable = 0, pwrite = 0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;
   int                fail_count, pending_count, words_checked;

   fcrl_req_if req_ch ();
   fcrl_rsp_if rsp_ch ();

   fifo_cache_replacement_list_core u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   fcrl_checker u_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
      .pending_count(pending_count), .words_checked(words_checked)
   );

   always #1 clock = ~clock;

   // idling control shared by both sides
   bit no_idle = 0;
   int hold_left = 0;
   int inserts_sent = 0, erases_sent = 0, caps_used = 0;
   logic [TAG_W-1:0] tag_pool[24];

   initial begin
      req_ch.valid   = 0;
      req_ch.op      = OP_INSERT;
      req_ch.key_tag = '0;
      rsp_ch.ready   = 0;
   end

   // receiver: random stalls, plus a long counted hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready = 0;
            hold_left--;
         end else begin
            rsp_ch.ready = no_idle ? 1'b1 : ($urandom_range(99) >= 23);
         end
      end
   end

   task automatic send_word(logic op, logic [TAG_W-1:0] tag);
      if (!no_idle) begin
         while ($urandom_range(99) < 23) begin
            req_ch.valid = 0;
            @(negedge clock);
         end
      end
      req_ch.valid   = 1;
      req_ch.op      = op;
      req_ch.key_tag = tag;
      if (op == OP_INSERT) inserts_sent++;
      else erases_sent++;
      forever begin
         #0.2;
         if (req_ch.ready) break;
         @(negedge clock);
      end
      @(negedge clock);
   endtask

   // wait for all results, allow an erase scan to drain, then write capacity
   task automatic write_capacity(logic [CSR_DW-1:0] value);
      req_ch.valid = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      psel    = 1;
      pwrite  = 1;
      paddr   = CSR_AW'(CSR_CAPACITY);
      pwdata  = value;
      penable = 0;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel    = 0;
      penable = 0;
      pwrite  = 0;
      caps_used++;
   endtask

   function automatic logic [TAG_W-1:0] pick_tag();
      return ($urandom_range(99) < 80) ? tag_pool[$urandom_range(23)] : $urandom;
   endfunction

   initial begin
      int caps[10] = '{64, 1, 127, 8, 3, 0, 33, 64, 16, 2};
      repeat (2) @(negedge clock);
      reset = 0;

      // directed: tag extremes, duplicates, misses
      send_word(OP_INSERT, 32'h0000_0000);
      send_word(OP_INSERT, 32'hFFFF_FFFF);
      send_word(OP_INSERT, 32'h5);
      send_word(OP_INSERT, 32'h5);
      send_word(OP_ERASE, 32'h5);
      send_word(OP_ERASE, 32'h5);
      send_word(OP_ERASE, 32'h5);
      send_word(OP_ERASE, 32'h1234_5678);
      send_word(OP_ERASE, 32'hFFFF_FFFF);
      send_word(OP_INSERT, 32'hAAAA_AAAA);
      send_word(OP_INSERT, 32'h5555_5555);
      // capacity lowered below the count
      write_capacity(2);
      repeat (3) send_word(OP_INSERT, $urandom);
      // out-of-range capacities
      write_capacity(0);
      send_word(OP_INSERT, 32'h8000_0001);
      send_word(OP_INSERT, 32'h7FFF_FFFE);
      send_word(OP_ERASE, 32'h7FFF_FFFE);
      write_capacity(127);
      send_word(OP_INSERT, 32'h0);
      send_word(OP_INSERT, 32'h0);
      send_word(OP_ERASE, 32'h0);

      // random phases across capacity settings
      foreach (caps[p]) begin
         write_capacity(caps[p]);
         foreach (tag_pool[i]) tag_pool[i] = $urandom;
         for (int n = 0; n < 193; n++) begin
            if (p == 3 && n == 20) hold_left = 400;
            no_idle = (p == 5 && n >= 40 && n < 140);
            if ($urandom_range(99) < 60) send_word(OP_INSERT, pick_tag());
            else send_word(OP_ERASE, pick_tag());
         end
         no_idle = 0;
      end

      req_ch.valid = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      $display("ran %0d inserts and %0d erases, %0d result words checked",
               inserts_sent, erases_sent, words_checked);
      $display("covered %0d capacity settings, including out-of-range and lowered",
               caps_used);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
